### rtl/assc_pkg.sv
// Package for the adaptive step size controller: payload, config and
// command/status types, clamp codes and the log2/exp2 table entry functions.
// Depends on nothing.
package assc_pkg;

  localparam int VW = 48;
  localparam int GW = 24;
  localparam int TB = 8;

  typedef enum logic [1:0] {
    CLAMP_NONE = 2'd0,
    CLAMP_MAX  = 2'd1,
    CLAMP_MIN  = 2'd2
  } clamp_t;

  localparam logic [2:0] REG_INTERVAL = 3'd0;
  localparam logic [2:0] REG_EXPONENT = 3'd1;
  localparam logic [2:0] REG_MIN_GROWTH = 3'd2;
  localparam logic [2:0] REG_MAX_GROWTH = 3'd3;
  localparam logic [2:0] REG_MIN_STEP = 3'd4;
  localparam logic [2:0] REG_MAX_STEP = 3'd5;
  localparam logic [2:0] REG_INIT_STEP = 3'd6;

  typedef struct packed {
    logic [VW-1:0] time_now;
    logic [VW-1:0] norm_now;
  } in_word_t;

  typedef struct packed {
    logic [VW-1:0] step_size;
    logic          step_updated;
    logic [1:0]    growth_clamp;
    logic [1:0]    step_clamp;
  } out_word_t;

  typedef struct packed {
    logic [7:0]    update_interval;
    logic [15:0]   gain_exp;
    logic [GW-1:0] gain_lo;
    logic [GW-1:0] gain_hi;
    logic [VW-1:0] min_step;
    logic [VW-1:0] max_step;
    logic [VW-1:0] initial_step;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic load;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
  } dp_sts_t;

  function automatic logic [15:0] log_entry(input int i);
    logic [63:0] m;
    logic [15:0] r;
    m = (64'(1 << TB) + 64'(i)) << (30 - TB);
    r = '0;
    for (int k = 0; k < 16; k++) begin
      m = (m * m) >> 30;
      r = r << 1;
      if (m >= (64'd1 << 31)) begin
        r[0] = 1'b1;
        m = m >> 1;
      end
    end
    return r;
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v, res, b;
    v = v_in;
    res = '0;
    b = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (b > v && res == 0) begin
        b = b >> 2;
      end
    end
    for (int k = 0; k < 32; k++) begin
      if (b != 0) begin
        if (v >= res + b) begin
          v = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
    end
    return res;
  endfunction

  function automatic logic [16:0] exp_entry(input int i);
    logic [63:0] x, r;
    x = 64'd1 << 30;
    r = 64'd1 << 31;
    for (int k = 1; k <= TB; k++) begin
      r = isqrt64(r << 30);
      if (((i >> (TB - k)) & 1) != 0) begin
        x = (x * r) >> 30;
      end
    end
    return 17'((x + 64'd8192) >> 14);
  endfunction

endpackage

### rtl/assc_ctrl.sv
// Controller for the adaptive step size controller: handshake, sequencing.
// Depends on assc_pkg.
module assc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  output assc_pkg::dp_cmd_t cmd,
  input  assc_pkg::dp_sts_t sts
);
  import assc_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_BUSY, S_OUT} state_t;
  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd.load = 1'b0;
    cmd.start = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          cmd.start = 1'b1;
          state_nxt = S_BUSY;
        end
      end
      S_BUSY: begin
        if (sts.done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_stall = (state_r != S_IDLE) || !rst_n;
  assign out_valid = (state_r == S_OUT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule

### rtl/assc_dp.sv
// Datapath for the adaptive step size controller: history, slopes, log/exp
// growth, step multiply and clamps, stepped through phases. Uses assc_pkg.
module assc_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  assc_pkg::dp_cmd_t  cmd,
  output assc_pkg::dp_sts_t  sts,
  input  assc_pkg::in_word_t in_word,
  input  assc_pkg::cfg_t     cfg,
  output assc_pkg::out_word_t out_word
);
  import assc_pkg::*;

  localparam logic [3:0] P_DIFF = 4'd0;
  localparam logic [3:0] P_LOG = 4'd1;
  localparam logic [3:0] P_SUM = 4'd2;
  localparam logic [3:0] P_MUL = 4'd3;
  localparam logic [3:0] P_EXP = 4'd4;
  localparam logic [3:0] P_GCL = 4'd5;
  localparam logic [3:0] P_SMUL = 4'd6;
  localparam logic [3:0] P_SCL = 4'd7;
  localparam logic [3:0] P_DONE = 4'd8;

  logic [VW-1:0] th_r [3];
  logic [VW-1:0] nh_r [3];
  logic [7:0] cnt_r;
  logic first_r;
  logic [VW-1:0] step_r;
  logic [3:0] ph_r;
  logic busy_r;
  logic [VW-1:0] d_r [4];
  logic [1:0] li_r;
  logic signed [23:0] l_r [4];
  logic signed [25:0] lr_r;
  logic signed [41:0] y_r;
  logic [GW-1:0] g_r;
  logic [1:0] gc_r, sc_r;
  logic special_r;
  logic [GW+32-1:0] pa_r;
  logic [GW+16-1:0] pb_r;
  logic [1:0] out_gc_r, out_sc_r;
  logic upd_r;

  logic [16:0] lt [256];
  logic [16:0] et [256];
  always_comb begin
    for (int i = 0; i < 256; i++) begin
      lt[i] = {1'b0, log_entry(i)};
      et[i] = exp_entry(i);
    end
  end

  function automatic logic [VW-1:0] absd(input logic [VW-1:0] a, input logic [VW-1:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  logic [VW-1:0] lv;
  logic [5:0] lp;
  logic [TB-1:0] lidx;
  always_comb begin
    lv = d_r[li_r];
    lp = '0;
    for (int k = 0; k < VW; k++) begin
      if (lv[k]) begin
        lp = 6'(k);
      end
    end
    if (lp >= 6'(TB)) begin
      lidx = TB'(lv >> (lp - 6'(TB)));
    end else begin
      lidx = TB'(lv << (6'(TB) - lp));
    end
  end

  logic signed [41:0] ip;
  logic [15:0] fr;
  logic [16:0] mant;
  logic [63:0] gx;
  always_comb begin
    ip = y_r >>> 16;
    fr = y_r[15:0];
    mant = et[fr[15:16-TB]];
    gx = '0;
    if (ip >= 8) begin
      gx = 64'hFFFFFF;
    end else if (ip >= 0) begin
      gx = 64'(mant) << ip[2:0];
    end else if (ip <= -40) begin
      gx = '0;
    end else begin
      gx = 64'(mant) >> 6'(-ip);
    end
    if (gx > 64'hFFFFFF) begin
      gx = 64'hFFFFFF;
    end
  end

  logic [VW-1:0] th1, th2, nh1, nh2;
  always_comb begin
    th1 = th_r[1];
    th2 = th_r[2];
    nh1 = nh_r[1];
    nh2 = nh_r[2];
  end

  logic [63:0] lo_v, r_v, r_fin;
  logic ovr;
  logic [1:0] sc_v;
  always_comb begin
    ovr = 1'b0;
    lo_v = 64'(pa_r >> 16);
    r_v = (64'(pb_r) << 16) + lo_v;
    if (64'(pb_r) > 64'hFFFF_FFFF) begin
      ovr = 1'b1;
    end else if (r_v > 64'({VW{1'b1}})) begin
      ovr = 1'b1;
    end
    r_fin = r_v;
    sc_v = CLAMP_NONE;
    if (ovr || r_v > 64'(cfg.max_step)) begin
      r_fin = 64'(cfg.max_step);
      sc_v = CLAMP_MAX;
    end
    if (r_fin < 64'(cfg.min_step)) begin
      r_fin = 64'(cfg.min_step);
      sc_v = CLAMP_MIN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        th_r[i] <= '0;
        nh_r[i] <= '0;
      end
      cnt_r <= '0;
      first_r <= 1'b1;
      step_r <= cfg.initial_step;
      busy_r <= 1'b0;
      ph_r <= P_DIFF;
      upd_r <= 1'b0;
      out_gc_r <= CLAMP_NONE;
      out_sc_r <= CLAMP_NONE;
    end else if (cmd.load) begin
      th_r[0] <= th_r[1];
      th_r[1] <= th_r[2];
      th_r[2] <= in_word.time_now;
      nh_r[0] <= nh_r[1];
      nh_r[1] <= nh_r[2];
      nh_r[2] <= in_word.norm_now;
      upd_r <= 1'b0;
      out_gc_r <= CLAMP_NONE;
      out_sc_r <= CLAMP_NONE;
      if (first_r) begin
        first_r <= 1'b0;
        step_r <= cfg.initial_step;
      end
      if ((first_r ? cfg.update_interval : cnt_r) == 8'd0) begin
        busy_r <= 1'b1;
        ph_r <= P_DIFF;
        cnt_r <= cfg.update_interval;
      end else begin
        busy_r <= 1'b1;
        ph_r <= P_DONE;
        cnt_r <= (first_r ? cfg.update_interval : cnt_r) - 8'd1;
      end
    end else if (busy_r) begin
      case (ph_r)
        P_DIFF: begin
          d_r[0] <= absd(nh1, nh_r[0]);
          d_r[1] <= absd(th2, th1);
          d_r[2] <= absd(th1, th_r[0]);
          d_r[3] <= absd(nh2, nh1);
          li_r <= 2'd0;
          gc_r <= CLAMP_NONE;
          special_r <= 1'b0;
          ph_r <= P_LOG;
        end
        P_LOG: begin
          l_r[li_r] <= $signed({2'b0, lp, 16'b0}) + $signed({7'b0, lt[lidx]});
          li_r <= li_r + 2'd1;
          if (li_r == 2'd3) begin
            ph_r <= P_SUM;
          end
          if (li_r == 2'd0) begin
            if (d_r[2] == 0 || d_r[3] == 0) begin
              g_r <= cfg.gain_hi;
              gc_r <= CLAMP_MAX;
              special_r <= 1'b1;
            end else if (d_r[0] == 0 || d_r[1] == 0) begin
              g_r <= cfg.gain_lo;
              gc_r <= CLAMP_MIN;
              special_r <= 1'b1;
            end
          end
        end
        P_SUM: begin
          lr_r <= 26'(l_r[0]) + 26'(l_r[1]) - 26'(l_r[2]) - 26'(l_r[3]);
          ph_r <= special_r ? P_GCL : P_MUL;
        end
        P_MUL: begin
          y_r <= 42'(($signed(lr_r) * $signed({1'b0, cfg.gain_exp})) >>> 12);
          ph_r <= P_EXP;
        end
        P_EXP: begin
          g_r <= GW'(gx);
          ph_r <= P_GCL;
        end
        P_GCL: begin
          logic [GW-1:0] g;
          logic [1:0] c;
          g = g_r;
          c = gc_r;
          if (g > cfg.gain_hi) begin
            g = cfg.gain_hi;
            c = CLAMP_MAX;
          end
          if (g < cfg.gain_lo) begin
            g = cfg.gain_lo;
            c = CLAMP_MIN;
          end
          g_r <= g;
          gc_r <= c;
          ph_r <= P_SMUL;
        end
        P_SMUL: begin
          pa_r <= step_r[31:0] * g_r;
          pb_r <= step_r[VW-1:32] * g_r;
          ph_r <= P_SCL;
        end
        P_SCL: begin
          step_r <= VW'(r_fin);
          out_sc_r <= sc_v;
          out_gc_r <= gc_r;
          upd_r <= 1'b1;
          cnt_r <= cnt_r - 8'd1;
          ph_r <= P_DONE;
        end
        P_DONE: begin
          busy_r <= 1'b0;
        end
        default: ph_r <= P_DONE;
      endcase
    end
  end

  assign sts.done = busy_r && (ph_r == P_DONE);
  assign out_word.step_size = step_r;
  assign out_word.step_updated = upd_r;
  assign out_word.growth_clamp = out_gc_r;
  assign out_word.step_clamp = out_sc_r;
endmodule

### rtl/adaptive_step_size_controller.sv
// Adaptive step size controller, top level; depends on assc_pkg, assc_ctrl and
// assc_dp. One word is taken at a time, and the next word is taken only after
// the result is given. A word that does not update the step goes straight to
// the done phase. An update word walks the datapath phases in order:
// differences, logs, sum, multiply, exp, growth clamp, step multiply and step
// clamp; when a zero difference selects a growth limit directly, the multiply
// and exp phases are skipped. A stalled result holds off the next word.
module adaptive_step_size_controller (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  assc_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output assc_pkg::out_word_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [47:0]         cfg_data
);
  import assc_pkg::*;

  cfg_t cfg_r;
  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.update_interval <= 8'd10;
      cfg_r.gain_exp <= 16'd4915;
      cfg_r.gain_lo <= 24'd16384;
      cfg_r.gain_hi <= 24'd131072;
      cfg_r.min_step <= 48'd1;
      cfg_r.max_step <= '1;
      cfg_r.initial_step <= 48'd16777216;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_INTERVAL: cfg_r.update_interval <= cfg_data[7:0];
        REG_EXPONENT: cfg_r.gain_exp <= cfg_data[15:0];
        REG_MIN_GROWTH: cfg_r.gain_lo <= cfg_data[23:0];
        REG_MAX_GROWTH: cfg_r.gain_hi <= cfg_data[23:0];
        REG_MIN_STEP: cfg_r.min_step <= cfg_data;
        REG_MAX_STEP: cfg_r.max_step <= cfg_data;
        REG_INIT_STEP: cfg_r.initial_step <= cfg_data;
        default: ;
      endcase
    end
  end

  assc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .sts(sts)
  );

  assc_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .in_word(in_data),
    .cfg(cfg_r), .out_word(out_data)
  );
endmodule
